// ===== sv/assert_macros.svh =====
// Assertion macros shared by the translator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked assertion, disabled while reset is asserted.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/prt_pkg.sv =====
// Shared widths, register indexes and victim rule codes of the page translator.
package prt_pkg;

    localparam int ADDR_W      = 32;
    localparam int TIME_W      = 32;
    localparam int PAGE_W      = 31;
    localparam int SHIFT_W     = 5;
    localparam int FRAME_OUT_W = 6;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int MODE_W     = 2;
    localparam int FRAMES_W   = 7;

    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FIFO   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LRU    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SECOND = 2'd2;

    localparam logic [MODE_W-1:0]   RESET_MODE   = MODE_FIFO;
    localparam logic [SHIFT_W-1:0]  RESET_OFFSET = 5'd12;
    localparam logic [FRAMES_W-1:0] RESET_FRAMES = 7'd64;

endpackage

// ===== sv/page_replacement_translator.sv =====
// Inverted page table translator with FIFO, LRU and second chance replacement.
//
// One reference at a time: the frame table sits in a RAM with one read and one
// write port, and a sequencer walks the managed frames (n = frames_in_use,
// clamped to 1..FRAMES) one entry per cycle. A hit ends the walk early; a miss
// walks all n frames, and a second chance replacement with no free frame adds
// a read-modify-write pass over all n frames. Valid and dirty marks live in
// flip-flops cleared by reset, so no clearing pass is needed and the block is
// ready right after reset. A finished result waits in the output register
// while the next reference is accepted.
module page_replacement_translator
    import prt_pkg::*;
#(
    parameter int FRAMES         = 64,
    parameter int HIT_COUNT_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // reference channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // [31:0] logical_address, [63:32] ref_time
    input  logic                  s_tuser,   // [0] func
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata    // [31:0] physical_address, [37:32] frame_index,
                                             // [38] page_hit, [39] swapped_out
);

`include "assert_macros.svh"

    localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W   = $clog2(FRAMES + 1);
    localparam int ENTRY_W = PAGE_W + TIME_W + TIME_W + HIT_COUNT_BITS;

    typedef struct packed {
        logic [PAGE_W-1:0]         page;
        logic [TIME_W-1:0]         load_time;
        logic [TIME_W-1:0]         use_time;
        logic [HIT_COUNT_BITS-1:0] hit_count;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SC_PASS,
        ST_COMMIT,
        ST_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [MODE_W-1:0]   cfg_mode_reg;
    logic [SHIFT_W-1:0]  cfg_offset_reg;
    logic [FRAMES_W-1:0] cfg_frames_reg;

    // current reference
    logic                wr_reg;
    logic [PAGE_W-1:0]   page_reg;
    logic [ADDR_W-1:0]   offset_reg;
    logic [SHIFT_W-1:0]  sh_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [CNT_W-1:0]    n_reg;

    // walk over the table
    logic [CNT_W-1:0]    rd_idx_reg;
    logic                pend_reg;
    logic [IDX_W-1:0]    pend_idx_reg;

    logic                hit_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    entry_t              hit_entry_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic [IDX_W-1:0]    fifo_idx_reg;
    logic [TIME_W-1:0]   fifo_time_reg;
    logic [IDX_W-1:0]    lru_idx_reg;
    logic [TIME_W-1:0]   lru_time_reg;
    logic [HIT_COUNT_BITS-1:0] least_reg;
    logic                have_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [TIME_W-1:0]   best_load_reg;
    logic [IDX_W-1:0]    victim_reg;

    logic [FRAMES-1:0]   valid_reg;
    logic [FRAMES-1:0]   dirty_reg;

    // finished result
    logic                res_hit_reg;
    logic                res_wb_reg;
    logic [IDX_W-1:0]    res_frame_reg;
    logic                m_tvalid_reg;
    logic [39:0]         m_tdata_reg;

    // table RAM
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    entry_t              rd_e;
    entry_t              wr_e;
    logic                in_accept;
    logic [SHIFT_W-1:0]  in_sh;
    logic [CNT_W-1:0]    in_n;
    logic                issue;
    logic                proc_first;
    logic                proc_last;
    logic                scan_hit;
    logic [HIT_COUNT_BITS-1:0] sc_cnt;
    logic                sc_cand;
    logic                sc_take;
    logic [IDX_W-1:0]    commit_frame;
    logic [ADDR_W-1:0]   res_phys;

    prt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FRAMES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign in_accept = s_tvalid && s_tready;

    assign rd_e       = entry_t'(ram_rdata);
    assign issue      = ((state_reg == ST_SCAN) || (state_reg == ST_SC_PASS))
                        && (rd_idx_reg < n_reg);
    assign ram_raddr  = rd_idx_reg[IDX_W-1:0];
    assign proc_first = (pend_idx_reg == '0);
    assign proc_last  = ((CNT_W'(pend_idx_reg) + CNT_W'(1)) == n_reg);
    assign scan_hit   = pend_reg && valid_reg[pend_idx_reg] && (rd_e.page == page_reg);

    // second chance: counts drop by the pass minimum, then once more when passed over
    assign sc_cnt  = rd_e.hit_count - least_reg;
    assign sc_cand = !have_reg || (rd_e.load_time < best_load_reg);
    assign sc_take = sc_cand && (sc_cnt == '0);

    assign commit_frame = hit_reg ? hit_idx_reg : victim_reg;
    assign res_phys     = (ADDR_W'(res_frame_reg) << sh_reg) | offset_reg;

    always_comb begin
        in_sh = (cfg_offset_reg == '0) ? SHIFT_W'(1) : cfg_offset_reg;
        if (cfg_frames_reg == '0) begin
            in_n = CNT_W'(1);
        end else if (32'(cfg_frames_reg) > 32'(FRAMES)) begin
            in_n = CNT_W'(FRAMES);
        end else begin
            in_n = CNT_W'(cfg_frames_reg);
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pend_idx_reg;
        wr_e      = rd_e;
        if ((state_reg == ST_SC_PASS) && pend_reg) begin
            ram_we         = 1'b1;
            wr_e.hit_count = (sc_cand && !sc_take) ? sc_cnt - HIT_COUNT_BITS'(1) : sc_cnt;
        end else if (state_reg == ST_COMMIT) begin
            ram_we    = 1'b1;
            ram_waddr = commit_frame;
            if (hit_reg) begin
                wr_e           = hit_entry_reg;
                wr_e.use_time  = now_reg;
                // saturate
                if (hit_entry_reg.hit_count != '1) begin
                    wr_e.hit_count = hit_entry_reg.hit_count + HIT_COUNT_BITS'(1);
                end
            end else begin
                wr_e.page      = page_reg;
                wr_e.load_time = now_reg;
                wr_e.use_time  = now_reg;
                wr_e.hit_count = '0;
            end
        end
        ram_wdata = wr_e;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cfg_mode_reg   <= RESET_MODE;
            cfg_offset_reg <= RESET_OFFSET;
            cfg_frames_reg <= RESET_FRAMES;
            rd_idx_reg     <= '0;
            n_reg          <= CNT_W'(1);
            pend_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            have_reg       <= 1'b0;
            valid_reg      <= '0;
            dirty_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_REPLACE_MODE:  cfg_mode_reg   <= cfg_data[MODE_W-1:0];
                    REG_OFFSET_BITS:   cfg_offset_reg <= cfg_data[SHIFT_W-1:0];
                    REG_FRAMES_IN_USE: cfg_frames_reg <= cfg_data[FRAMES_W-1:0];
                    default: ;
                endcase
            end

            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (issue) begin
                rd_idx_reg   <= rd_idx_reg + CNT_W'(1);
                pend_idx_reg <= rd_idx_reg[IDX_W-1:0];
            end
            pend_reg <= issue;

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        wr_reg         <= s_tuser;
                        sh_reg         <= in_sh;
                        page_reg       <= PAGE_W'(s_tdata[ADDR_W-1:0] >> in_sh);
                        offset_reg     <= s_tdata[ADDR_W-1:0] & ~({ADDR_W{1'b1}} << in_sh);
                        now_reg        <= s_tdata[ADDR_W+TIME_W-1:ADDR_W];
                        n_reg          <= in_n;
                        rd_idx_reg     <= '0;
                        hit_reg        <= 1'b0;
                        free_found_reg <= 1'b0;
                        state_reg      <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (pend_reg) begin
                        if (!valid_reg[pend_idx_reg] && !free_found_reg) begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= pend_idx_reg;
                        end
                        if (proc_first || (rd_e.load_time < fifo_time_reg)) begin
                            fifo_idx_reg  <= pend_idx_reg;
                            fifo_time_reg <= rd_e.load_time;
                        end
                        if (proc_first || (rd_e.use_time < lru_time_reg)) begin
                            lru_idx_reg  <= pend_idx_reg;
                            lru_time_reg <= rd_e.use_time;
                        end
                        if (proc_first || (rd_e.hit_count < least_reg)) begin
                            least_reg <= rd_e.hit_count;
                        end
                        if (scan_hit) begin
                            hit_reg       <= 1'b1;
                            hit_idx_reg   <= pend_idx_reg;
                            hit_entry_reg <= rd_e;
                            pend_reg      <= 1'b0;
                            state_reg     <= ST_COMMIT;
                        end else if (proc_last) begin
                            pend_reg  <= 1'b0;
                            state_reg <= ST_DECIDE;
                        end
                    end
                end
                ST_DECIDE: begin
                    state_reg <= ST_COMMIT;
                    if (free_found_reg) begin
                        victim_reg <= free_idx_reg;
                    end else begin
                        case (cfg_mode_reg)
                            MODE_LRU: victim_reg <= lru_idx_reg;
                            MODE_SECOND: begin
                                rd_idx_reg <= '0;
                                have_reg   <= 1'b0;
                                state_reg  <= ST_SC_PASS;
                            end
                            default: victim_reg <= fifo_idx_reg;
                        endcase
                    end
                end
                ST_SC_PASS: begin
                    if (pend_reg) begin
                        if (sc_take) begin
                            have_reg      <= 1'b1;
                            best_idx_reg  <= pend_idx_reg;
                            best_load_reg <= rd_e.load_time;
                        end
                        if (proc_last) begin
                            victim_reg <= sc_take ? pend_idx_reg : best_idx_reg;
                            pend_reg   <= 1'b0;
                            state_reg  <= ST_COMMIT;
                        end
                    end
                end
                ST_COMMIT: begin
                    res_frame_reg <= commit_frame;
                    res_hit_reg   <= hit_reg;
                    if (hit_reg) begin
                        res_wb_reg <= 1'b0;
                        if (wr_reg) begin
                            dirty_reg[commit_frame] <= 1'b1;
                        end
                    end else begin
                        res_wb_reg              <= dirty_reg[commit_frame];
                        dirty_reg[commit_frame] <= wr_reg;
                        valid_reg[commit_frame] <= 1'b1;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    // hold until the previous beat has left the output register
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {res_wb_reg, res_hit_reg,
                                         FRAME_OUT_W'(res_frame_reg), res_phys};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `ASSERT_AT(a_busy_after_accept, aclk, aresetn, in_accept |=> !s_tready, "accepted while busy")
    `ASSERT_AT(a_hit_no_writeback, aclk, aresetn, m_tvalid && m_tdata[38] |-> !m_tdata[39], "write-back flagged on a hit")
    `ASSERT_AT(a_valid_monotone, aclk, aresetn, 1'b1 |=> ($countones(valid_reg) >= $past($countones(valid_reg))), "frame lost its valid mark")
    `ASSERT_AT(a_walk_in_range, aclk, aresetn, rd_idx_reg <= n_reg, "table walk ran past the managed frames")

endmodule

// ===== sv/prt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module prt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== bench/page_replacement_translator_tb.sv =====
// Self-checking bench for the page translator: directed, hot page and random reference tests.
module page_replacement_translator_tb;
    import prt_pkg::*;

    localparam int NFRAMES     = 64;
    localparam int CNT_W       = 16;
    localparam int HOT_HITS    = 24;
    localparam int STUCK_LIMIT = 2000;
    localparam int SETTLE      = 2 * NFRAMES + 16;

    // spare victim rule code, decoded as fifo
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic                   swapped_out;
        logic                   page_hit;
        logic [FRAME_OUT_W-1:0] frame_index;
        logic [ADDR_W-1:0]      physical_address;
    } xlat_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [63:0]           s_tdata;   // [31:0] logical_address, [63:32] ref_time
    logic                  s_tuser;   // [0] func
    logic                  m_tvalid;
    logic                  m_tready;
    logic [39:0]           m_tdata;   // [31:0] physical_address, [37:32] frame_index,
                                      // [38] page_hit, [39] swapped_out

    // shadow of the frame table and the registers
    logic [PAGE_W-1:0]   pg_tag    [NFRAMES];
    bit                  pg_valid  [NFRAMES];
    bit                  pg_dirty  [NFRAMES];
    logic [TIME_W-1:0]   pg_loaded [NFRAMES];
    logic [TIME_W-1:0]   pg_used   [NFRAMES];
    logic [CNT_W-1:0]    pg_hits   [NFRAMES];
    logic [MODE_W-1:0]   cur_mode;
    logic [SHIFT_W-1:0]  cur_shift;
    logic [FRAMES_W-1:0] cur_frames;

    xlat_t             pending_xlat [$];
    xlat_t             got_xlat;
    xlat_t             want_xlat;
    int                mismatches  = 0;
    int                stuck_cycles = 0;
    int                rx_hold;
    int                rx_draw;
    bit                idle_on = 1'b1;
    logic [TIME_W-1:0] ref_clock = '0;

    page_replacement_translator #(
        .FRAMES         (NFRAMES),
        .HIT_COUNT_BITS (CNT_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Translate one reference against the shadow table and update it.
    function automatic xlat_t translate(bit wr, logic [ADDR_W-1:0] addr, logic [TIME_W-1:0] now);
        int                sh;
        int                n;
        int                fr;
        int                i;
        bit                hit;
        bit                have;
        logic [PAGE_W-1:0] page;
        logic [ADDR_W-1:0] ofs;
        logic [CNT_W-1:0]  least;
        xlat_t             r;
        sh   = (cur_shift == 0) ? 1 : int'(cur_shift);
        n    = (cur_frames == 0) ? 1 : (cur_frames > NFRAMES) ? NFRAMES : int'(cur_frames);
        page = PAGE_W'(addr >> sh);
        ofs  = addr & ((32'd1 << sh) - 32'd1);
        hit  = 1'b0;
        fr   = 0;
        for (i = 0; i < n && !hit; i++) begin
            if (pg_valid[i] && pg_tag[i] == page) begin
                fr  = i;
                hit = 1'b1;
            end
        end
        r.swapped_out = 1'b0;
        if (hit) begin
            pg_used[fr] = now;
            if (pg_hits[fr] != {CNT_W{1'b1}}) pg_hits[fr] = pg_hits[fr] + 1'b1;
            if (wr) pg_dirty[fr] = 1'b1;
        end else begin
            have = 1'b0;
            for (i = 0; i < n && !have; i++) begin
                if (!pg_valid[i]) begin
                    fr   = i;
                    have = 1'b1;
                end
            end
            if (!have) begin
                fr = 0;
                if (cur_mode == MODE_LRU) begin
                    for (i = 1; i < n; i++)
                        if (pg_used[i] < pg_used[fr]) fr = i;
                end else if (cur_mode == MODE_SECOND) begin
                    // skip the victimless passes at once, then run the final pass
                    least = pg_hits[0];
                    for (i = 1; i < n; i++)
                        if (pg_hits[i] < least) least = pg_hits[i];
                    for (i = 0; i < n; i++)
                        pg_hits[i] = pg_hits[i] - least;
                    for (i = 0; i < n; i++) begin
                        if (!have || pg_loaded[i] < pg_loaded[fr]) begin
                            if (pg_hits[i] == 0) begin
                                fr   = i;
                                have = 1'b1;
                            end else begin
                                pg_hits[i] = pg_hits[i] - 1'b1;
                            end
                        end
                    end
                end else begin
                    for (i = 1; i < n; i++)
                        if (pg_loaded[i] < pg_loaded[fr]) fr = i;
                end
            end
            r.swapped_out = pg_dirty[fr];
            pg_dirty[fr]  = wr;
            pg_tag[fr]    = page;
            pg_valid[fr]  = 1'b1;
            pg_loaded[fr] = now;
            pg_used[fr]   = now;
            pg_hits[fr]   = '0;
        end
        r.page_hit         = hit;
        r.frame_index      = FRAME_OUT_W'(fr);
        r.physical_address = ADDR_W'((64'(fr) << sh) | 64'(ofs));
        return r;
    endfunction

    task automatic report_mismatch(string what, xlat_t want, xlat_t got);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch on %0s at %0t: expected %h got %h", what, $time, want, got);
    endtask

    // Drive one reference and hold it until the beat is taken.
    task automatic send_ref(bit wr, logic [ADDR_W-1:0] addr, logic [TIME_W-1:0] now);
        int gap;
        gap = idle_on ? $urandom_range(15, 0) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, addr};
        s_tuser  <= wr;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_xlat.push_back(translate(wr, addr, now));
    endtask

    // Stop sending and wait for every outstanding result.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_xlat.size() != 0) @(posedge aclk);
    endtask

    task automatic set_config(logic [MODE_W-1:0] mode, logic [SHIFT_W-1:0] shift,
                              logic [FRAMES_W-1:0] frames);
        logic [CFG_IDX_W-1:0]  regs [3];
        logic [CFG_DATA_W-1:0] vals [3];
        int                    k;
        regs[0] = REG_REPLACE_MODE;
        regs[1] = REG_OFFSET_BITS;
        regs[2] = REG_FRAMES_IN_USE;
        vals[0] = CFG_DATA_W'(mode);
        vals[1] = CFG_DATA_W'(shift);
        vals[2] = CFG_DATA_W'(frames);
        wait_idle();
        for (k = 0; k < 3; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid  <= 1'b0;
        cur_mode   = mode;
        cur_shift  = shift;
        cur_frames = frames;
    endtask

    task automatic test_directed();
        // reset settings: fifo, 4 KiB pages, all frames; field extremes, read and write hits
        send_ref(1'b0, 32'h0000_0000, 32'h0000_0000);
        send_ref(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_ref(1'b0, 32'h0000_0FFF, 32'd1);
        send_ref(1'b1, 32'h0000_0123, 32'd2);
        // zero offset width acts as one, zero frames as one: misses evict dirty frame 0
        set_config(MODE_SPARE, 5'd0, 7'd0);
        send_ref(1'b1, 32'h0000_0002, 32'd3);
        send_ref(1'b0, 32'h0000_0004, 32'd4);
        send_ref(1'b0, 32'h0000_0005, 32'd5);
        // widest offset, oversized frame count: frame bits above bit 31 drop out
        set_config(MODE_LRU, 5'd31, 7'd127);
        send_ref(1'b0, 32'h8000_0001, 32'd6);
        send_ref(1'b1, 32'h7FFF_FFFF, 32'd7);
        send_ref(1'b0, 32'h0000_0000, 32'd8);
        // second chance over two frames
        set_config(MODE_SECOND, 5'd1, 7'd2);
        send_ref(1'b1, 32'h0000_0000, 32'd9);
        send_ref(1'b0, 32'h0000_0002, 32'd10);
        send_ref(1'b0, 32'h0000_0000, 32'd11);
        send_ref(1'b1, 32'h0000_0004, 32'd12);
        send_ref(1'b0, 32'h0000_0006, 32'd13);
        send_ref(1'b0, 32'h0000_0002, 32'd14);
        // lru with equal use times, lowest index wins
        set_config(MODE_LRU, 5'd1, 7'd2);
        send_ref(1'b0, 32'h0000_0008, 32'd14);
        send_ref(1'b0, 32'h0000_000A, 32'd14);
        ref_clock = 32'd20;
    endtask

    // Hit one page many times back to back, then force second chance victims.
    task automatic test_hot_page();
        int k;
        idle_on = 1'b0;
        set_config(MODE_SECOND, 5'd12, 7'd2);
        send_ref(1'b0, 32'h0001_0000, ref_clock);
        send_ref(1'b0, 32'h0002_0000, ref_clock + 1);
        for (k = 0; k < HOT_HITS; k++)
            send_ref(k[0], 32'h0001_0ABC, ref_clock + 2);
        send_ref(1'b0, 32'h0003_0000, ref_clock + 3);
        send_ref(1'b1, 32'h0004_0000, ref_clock + 4);
        send_ref(1'b0, 32'h0005_0000, ref_clock + 5);
        send_ref(1'b0, 32'h0001_0000, ref_clock + 6);
        ref_clock = ref_clock + 7;
        idle_on = 1'b1;
    endtask

    task automatic test_random(int phases, int per_phase);
        int                  p;
        int                  k;
        int                  n_eff;
        int                  pool_n;
        int                  sh;
        logic [ADDR_W-1:0]   pool [NFRAMES + 4];
        logic [ADDR_W-1:0]   addr;
        logic [SHIFT_W-1:0]  shift;
        logic [FRAMES_W-1:0] frames;
        for (p = 0; p < phases; p++) begin
            // mostly small tables so replacement happens often
            case ($urandom_range(9, 0))
                0:       frames = FRAMES_W'(NFRAMES);
                1:       frames = FRAMES_W'($urandom_range(127, 65));
                2:       frames = '0;
                3:       frames = FRAMES_W'($urandom_range(NFRAMES, 9));
                default: frames = FRAMES_W'($urandom_range(8, 1));
            endcase
            shift = SHIFT_W'($urandom_range(31, 0));
            set_config(MODE_W'(p), shift, frames);
            idle_on = ($urandom_range(3, 0) != 0);
            n_eff  = (frames == 0) ? 1 : (frames > NFRAMES) ? NFRAMES : int'(frames);
            pool_n = n_eff + $urandom_range(3, 0);
            for (k = 0; k < pool_n; k++) pool[k] = $urandom();
            sh = (shift == 0) ? 1 : int'(shift);
            for (k = 0; k < per_phase; k++) begin
                if ($urandom_range(19, 0) == 0)
                    addr = $urandom();
                else
                    addr = (pool[$urandom_range(pool_n - 1, 0)] << sh)
                         | ($urandom() & ((32'd1 << sh) - 32'd1));
                if ($urandom_range(19, 0) == 0)
                    ref_clock = $urandom();
                else
                    ref_clock = ref_clock + $urandom_range(3, 0);
                send_ref($urandom_range(1, 0), addr, ref_clock);
                if ($urandom_range(39, 0) == 0) wait_idle();
            end
        end
        idle_on = 1'b1;
    endtask

    // result side: while idle_on is set, stall a random number of cycles after each beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else if (m_tready && m_tvalid) begin
            rx_draw = idle_on ? $urandom_range(15, 0) : 0;
            if (rx_draw != 0) begin
                m_tready <= 1'b0;
                rx_hold  <= rx_draw - 1;
            end
        end else if (!m_tready) begin
            if (rx_hold == 0) m_tready <= 1'b1;
            else rx_hold <= rx_hold - 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_xlat = m_tdata;
            if (pending_xlat.size() == 0) begin
                report_mismatch("unexpected result", '0, got_xlat);
            end else begin
                want_xlat = pending_xlat.pop_front();
                if (got_xlat.physical_address !== want_xlat.physical_address)
                    report_mismatch("physical_address", want_xlat, got_xlat);
                if (got_xlat.frame_index !== want_xlat.frame_index)
                    report_mismatch("frame_index", want_xlat, got_xlat);
                if (got_xlat.page_hit !== want_xlat.page_hit)
                    report_mismatch("page_hit", want_xlat, got_xlat);
                if (got_xlat.swapped_out !== want_xlat.swapped_out)
                    report_mismatch("swapped_out", want_xlat, got_xlat);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_REPLACE_MODE;
        cfg_data   <= '0;
        cur_mode   = RESET_MODE;
        cur_shift  = RESET_OFFSET;
        cur_frames = RESET_FRAMES;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_hot_page();
        test_random(16, 44);
        wait_idle();
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
